// ===== src/ggh_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and the arctangent table of the go-to-goal heading controller
// no dependencies; used by every module of the block

package ggh_pkg;

    // sizing of the datapath
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int POSITION_BITS   = 16;

    localparam int ANGLE_W  = ANGLE_FRAC_BITS + 3;   // pose and goal headings
    localparam int TURN_W   = ANGLE_FRAC_BITS + 4;   // turn rate and rounded bearing
    localparam int ERR_W    = TURN_W + 1;            // heading error before and after wrap
    localparam int DIFF_W   = POSITION_BITS + 1;     // position offsets
    localparam int PRESCALE = 14;                    // vectors enter the cordic times 2^14
    localparam int VEC_W    = DIFF_W + PRESCALE + 3; // room for the cordic gain
    localparam int Z_W      = 34;                    // q30 angle accumulator
    localparam int SQ_W     = 2 * POSITION_BITS;     // one squared offset
    localparam int SUM_W    = SQ_W + 1;              // squared distance
    localparam int STEP_W   = $clog2(CORDIC_STEPS);
    localparam int TAB_W    = 5;                     // index width of the arctangent table

    // configuration register widths
    localparam int TOL_W    = 13;
    localparam int GAIN_W   = 4;
    localparam int LIM_W    = 15;
    localparam int WIN_W    = 14;
    localparam int RAD_W    = 12;
    localparam int RADSQ_W  = 2 * RAD_W;
    localparam int CFG_W    = 15;
    localparam int CFG_A_W  = 3;
    localparam int WIDE_W   = ERR_W + LIM_W;         // common width for magnitude compares
    localparam int PROD_W   = ERR_W + GAIN_W;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_ANGLE_TOL  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_TURN_GAIN  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_TURN_LIMIT = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_MIN_TURN   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ARRIVE_RAD = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_HEAD_WIN   = 3'd5;

    // register reset values
    localparam logic [TOL_W-1:0] RST_ANGLE_TOL  = 13'd205;
    localparam logic [GAIN_W-1:0] RST_TURN_GAIN = 4'd3;
    localparam logic [LIM_W-1:0] RST_TURN_LIMIT = 15'd4096;
    localparam logic [LIM_W-1:0] RST_MIN_TURN   = 15'd1229;
    localparam logic [RAD_W-1:0] RST_ARRIVE_RAD = 12'd150;
    localparam logic [WIN_W-1:0] RST_HEAD_WIN   = 14'd2145;

    // operation codes
    localparam logic [1:0] OP_ANGLE     = 2'd0;
    localparam logic [1:0] OP_ANGLE_MIN = 2'd1;
    localparam logic [1:0] OP_POINT     = 2'd2;

    // angle constants
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam int     RND_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] PI_Z = Z_W'(PI_Q30);
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'sd1 <<< (RND_SHIFT - 1));
    localparam longint PI_ANGLE = (PI_Q30 + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    localparam logic signed [ERR_W-1:0] PI_ERR     = ERR_W'(PI_ANGLE);
    localparam logic signed [ERR_W-1:0] TWO_PI_ERR = ERR_W'(2 * PI_ANGLE);

    // speed from clamped squared distance: (sq + 5) / 10 by reciprocal multiply
    localparam int SQC_W      = 10;
    localparam int SPEED_W    = 7;
    localparam int RECIP_W    = 13;
    localparam int SPD_SHIFT  = 16;
    localparam int SPD_PROD_W = SQC_W + 1 + RECIP_W;
    localparam logic [SUM_W-1:0]   SQ_MAX     = SUM_W'(1000);
    localparam logic [SUM_W-1:0]   SQ_MIN     = SUM_W'(500);
    localparam logic [SQC_W:0]     SPD_ROUND  = 11'd5;
    localparam logic [RECIP_W-1:0] SPD_RECIP  = 13'd6554;  // ceil(2^16 / 10)

    // stream packing
    localparam int IN_FIELDS_W = 2 * ANGLE_W + 4 * POSITION_BITS;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int TH_LSB      = 0;
    localparam int TX_LSB      = TH_LSB + ANGLE_W;
    localparam int TY_LSB      = TX_LSB + POSITION_BITS;
    localparam int CX_LSB      = TY_LSB + POSITION_BITS;
    localparam int CY_LSB      = CX_LSB + POSITION_BITS;
    localparam int CH_LSB      = CY_LSB + POSITION_BITS;
    localparam int OUT_FIELDS_W = SPEED_W + TURN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } t_vec;

    typedef struct packed {
        logic [1:0]                op;
        logic                      zero;
        logic signed [ANGLE_W-1:0] th;
        logic signed [ANGLE_W-1:0] ch;
        logic [SQ_W-1:0]           dx2;
        logic [SQ_W-1:0]           dy2;
    } t_side;

    typedef struct packed {
        logic [TOL_W-1:0]   tol;
        logic [GAIN_W-1:0]  gain;
        logic [LIM_W-1:0]   lim;
        logic [LIM_W-1:0]   min_rate;
        logic [WIN_W-1:0]   win;
        logic [RADSQ_W-1:0] rad_sq;
    } t_cfg;

    // atan(2^-i) in q30, truncated
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [TAB_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return Z_W'(v);
    endfunction

endpackage

// ===== src/go_to_goal_heading_controller.sv =====
`timescale 1ns / 1ps
// top level of the go-to-goal heading controller: stream ports, register file,
// input stage, cordic cell chain and back end; depends on ggh_pkg and all ggh_ modules
//
// Each item carries an operation, a goal and the current pose, and yields exactly one
// result item: an arrived flag, a forward speed and a signed turn rate in Q3.12 rad/s.
// In the angle modes the heading error (goal minus current) is wrapped to [-pi, pi];
// inside angle_tolerance the block reports arrival, otherwise it turns at
// error * turn_gain clamped to turn_limit, and the minimum-rate mode lifts a nonzero
// turn up to min_turn_rate. In point mode (operation bit 1 set) the block reports
// arrival inside arrive_radius; otherwise the bearing to the goal comes from a vectoring
// cordic, and the robot turns in place while the wrapped bearing error exceeds
// heading_window, else drives at (squared distance clamped to 500..1000 + 5) / 10 mm/s
// and turns at the bearing error. The datapath is a row of identical cordic cells, one
// per step, with an input stage ahead and four back-end stages behind; every stage has
// its own item register and hands over whenever the next one is free. One item is
// accepted per clock while the output is not stalled; each item passes through
// 1 + CORDIC_STEPS + 4 = 21 registers, the last of which is the output register. The
// output register holds a result while m_axis_tready is low and the stages behind it
// keep filling. The user must write registers through the cfg port only while no item
// is in flight; the block itself does not enforce this. The arrival radius is squared
// in the cycle after its write.

module go_to_goal_heading_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_heading, target_x, target_y, current_x, current_y, current_heading, zero pad
    input  logic [ggh_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic [1:0]                          s_axis_tuser,
    // result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // linear_speed, turn_rate, zero pad
    output logic [ggh_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // arrived
    output logic [0:0]                          m_axis_tuser,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ggh_pkg::CFG_A_W-1:0]         i_cfg_addr,
    input  logic [ggh_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int N = ggh_pkg::CORDIC_STEPS;

    // register file
    logic [ggh_pkg::TOL_W-1:0]      r_angle_tol;
    logic [ggh_pkg::GAIN_W-1:0]     r_turn_gain;
    logic [ggh_pkg::LIM_W-1:0]      r_turn_limit;
    logic [ggh_pkg::LIM_W-1:0]      r_min_turn;
    logic [ggh_pkg::RAD_W-1:0]      r_arrive_rad;
    logic [ggh_pkg::WIN_W-1:0]      r_head_win;
    logic [ggh_pkg::RADSQ_W-1:0]    r_rad_sq;
    ggh_pkg::t_cfg                  w_cfg;

    // cell chain links: index i feeds cell i
    logic                           w_valid [0:N];
    logic                           w_ready [0:N];
    ggh_pkg::t_vec                  w_vec   [0:N];
    ggh_pkg::t_side                 w_side  [0:N];

    logic                           w_arrived;
    logic [ggh_pkg::SPEED_W-1:0]    w_speed;
    logic signed [ggh_pkg::TURN_W-1:0] w_turn;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_tol  <= ggh_pkg::RST_ANGLE_TOL;
            r_turn_gain  <= ggh_pkg::RST_TURN_GAIN;
            r_turn_limit <= ggh_pkg::RST_TURN_LIMIT;
            r_min_turn   <= ggh_pkg::RST_MIN_TURN;
            r_arrive_rad <= ggh_pkg::RST_ARRIVE_RAD;
            r_head_win   <= ggh_pkg::RST_HEAD_WIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                ggh_pkg::REG_ANGLE_TOL:  r_angle_tol  <= i_cfg_data[ggh_pkg::TOL_W-1:0];
                ggh_pkg::REG_TURN_GAIN:  r_turn_gain  <= i_cfg_data[ggh_pkg::GAIN_W-1:0];
                ggh_pkg::REG_TURN_LIMIT: r_turn_limit <= i_cfg_data[ggh_pkg::LIM_W-1:0];
                ggh_pkg::REG_MIN_TURN:   r_min_turn   <= i_cfg_data[ggh_pkg::LIM_W-1:0];
                ggh_pkg::REG_ARRIVE_RAD: r_arrive_rad <= i_cfg_data[ggh_pkg::RAD_W-1:0];
                ggh_pkg::REG_HEAD_WIN:   r_head_win   <= i_cfg_data[ggh_pkg::WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // squared radius kept in a register so the arrival compare needs no multiplier
    always_ff @(posedge i_clk) begin
        r_rad_sq <= ggh_pkg::RADSQ_W'(r_arrive_rad) * ggh_pkg::RADSQ_W'(r_arrive_rad);
    end

    always_comb begin
        w_cfg.tol      = r_angle_tol;
        w_cfg.gain     = r_turn_gain;
        w_cfg.lim      = r_turn_limit;
        w_cfg.min_rate = r_min_turn;
        w_cfg.win      = r_head_win;
        w_cfg.rad_sq   = r_rad_sq;
    end

    // input stage: unpack the item and set up the cordic vector
    ggh_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_th    (s_axis_tdata[ggh_pkg::TH_LSB +: ggh_pkg::ANGLE_W]),
        .i_tx    (s_axis_tdata[ggh_pkg::TX_LSB +: ggh_pkg::POSITION_BITS]),
        .i_ty    (s_axis_tdata[ggh_pkg::TY_LSB +: ggh_pkg::POSITION_BITS]),
        .i_cx    (s_axis_tdata[ggh_pkg::CX_LSB +: ggh_pkg::POSITION_BITS]),
        .i_cy    (s_axis_tdata[ggh_pkg::CY_LSB +: ggh_pkg::POSITION_BITS]),
        .i_ch    (s_axis_tdata[ggh_pkg::CH_LSB +: ggh_pkg::ANGLE_W]),
        .i_ready (w_ready[0]),
        .o_valid (w_valid[0]),
        .o_vec   (w_vec[0]),
        .o_side  (w_side[0])
    );

    // one cell per cordic step; the pose rides along beside the vector
    for (genvar i = 0; i < N; i++) begin : g_cell
        ggh_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (ggh_pkg::STEP_W'(i)),
            .i_valid (w_valid[i]),
            .o_ready (w_ready[i]),
            .i_vec   (w_vec[i]),
            .i_side  (w_side[i]),
            .i_ready (w_ready[i+1]),
            .o_valid (w_valid[i+1]),
            .o_vec   (w_vec[i+1]),
            .o_side  (w_side[i+1])
        );
    end

    // back end; its last stage is the output register
    ggh_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_valid[N]),
        .o_ready   (w_ready[N]),
        .i_z       (w_vec[N].z),
        .i_side    (w_side[N]),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_arrived (w_arrived),
        .o_speed   (w_speed),
        .o_turn    (w_turn)
    );

    assign m_axis_tuser = w_arrived;
    assign m_axis_tdata = ggh_pkg::OUT_DATA_W'({w_turn, w_speed});

    // arrival always comes with zero motion
    a_arrived_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("arrived result carries motion");

    // speed is zero or within the driving band
    a_speed_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_speed == '0) ||
                          ((w_speed >= ggh_pkg::SPEED_W'(50)) &&
                           (w_speed <= ggh_pkg::SPEED_W'(100))))
        else $error("linear speed outside its band");

    // an empty output register means no stage can be blocked
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // a stalled result stays put until it is taken
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

// ===== src/ggh_prep.sv =====
`timescale 1ns / 1ps
// input stage: position offsets, squared offsets and the cordic pre-rotation
// depends on ggh_pkg

module ggh_prep (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [1:0]                                i_op,
    input  logic signed [ggh_pkg::ANGLE_W-1:0]        i_th,
    input  logic signed [ggh_pkg::POSITION_BITS-1:0]  i_tx,
    input  logic signed [ggh_pkg::POSITION_BITS-1:0]  i_ty,
    input  logic signed [ggh_pkg::POSITION_BITS-1:0]  i_cx,
    input  logic signed [ggh_pkg::POSITION_BITS-1:0]  i_cy,
    input  logic signed [ggh_pkg::ANGLE_W-1:0]        i_ch,
    input  logic                                      i_ready,
    output logic                                      o_valid,
    output ggh_pkg::t_vec                             o_vec,
    output ggh_pkg::t_side                            o_side
);

    logic                                   r_valid;
    ggh_pkg::t_vec                          r_vec;
    ggh_pkg::t_side                         r_side;
    ggh_pkg::t_vec                          n_vec;
    ggh_pkg::t_side                         n_side;
    logic signed [ggh_pkg::DIFF_W-1:0]      w_dx;
    logic signed [ggh_pkg::DIFF_W-1:0]      w_dy;
    logic signed [ggh_pkg::VEC_W-1:0]       w_xs;
    logic signed [ggh_pkg::VEC_W-1:0]       w_ys;
    logic signed [2*ggh_pkg::DIFF_W-1:0]    w_dx2;
    logic signed [2*ggh_pkg::DIFF_W-1:0]    w_dy2;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

    always_comb begin
        w_dx  = ggh_pkg::DIFF_W'(i_tx) - ggh_pkg::DIFF_W'(i_cx);
        w_dy  = ggh_pkg::DIFF_W'(i_ty) - ggh_pkg::DIFF_W'(i_cy);
        w_xs  = ggh_pkg::VEC_W'(w_dx) <<< ggh_pkg::PRESCALE;
        w_ys  = ggh_pkg::VEC_W'(w_dy) <<< ggh_pkg::PRESCALE;
        w_dx2 = w_dx * w_dx;
        w_dy2 = w_dy * w_dy;

        // left half plane: rotate by pi so the cordic only sees x >= 0
        if (w_dx[ggh_pkg::DIFF_W-1]) begin
            n_vec.x = -w_xs;
            n_vec.y = -w_ys;
            n_vec.z = w_dy[ggh_pkg::DIFF_W-1] ? -ggh_pkg::PI_Z : ggh_pkg::PI_Z;
        end else begin
            n_vec.x = w_xs;
            n_vec.y = w_ys;
            n_vec.z = '0;
        end

        n_side.op   = i_op;
        n_side.zero = (w_dx == '0) && (w_dy == '0);
        n_side.th   = i_th;
        n_side.ch   = i_ch;
        n_side.dx2  = w_dx2[ggh_pkg::SQ_W-1:0];
        n_side.dy2  = w_dy2[ggh_pkg::SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec  <= n_vec;
            r_side <= n_side;
        end
    end

endmodule

// ===== src/ggh_cordic_cell.sv =====
`timescale 1ns / 1ps
// one vectoring cordic step with its own item register and handshake
// depends on ggh_pkg

module ggh_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ggh_pkg::STEP_W-1:0]   i_step,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ggh_pkg::t_vec                i_vec,
    input  ggh_pkg::t_side               i_side,
    input  logic                         i_ready,
    output logic                         o_valid,
    output ggh_pkg::t_vec                o_vec,
    output ggh_pkg::t_side               o_side
);

    logic                               r_valid;
    ggh_pkg::t_vec                      r_vec;
    ggh_pkg::t_side                     r_side;
    ggh_pkg::t_vec                      n_vec;
    logic signed [ggh_pkg::VEC_W-1:0]   w_xs;
    logic signed [ggh_pkg::VEC_W-1:0]   w_ys;
    logic signed [ggh_pkg::Z_W-1:0]     w_atan;
    logic                               w_up;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

    always_comb begin
        w_xs   = i_vec.x >>> i_step;
        w_ys   = i_vec.y >>> i_step;
        w_atan = ggh_pkg::atan_q30(ggh_pkg::TAB_W'(i_step));
        // rotate clockwise while y is strictly positive
        w_up   = !i_vec.y[ggh_pkg::VEC_W-1] && (i_vec.y != '0);
        if (w_up) begin
            n_vec.x = i_vec.x + w_ys;
            n_vec.y = i_vec.y - w_xs;
            n_vec.z = i_vec.z + w_atan;
        end else begin
            n_vec.x = i_vec.x - w_ys;
            n_vec.y = i_vec.y + w_xs;
            n_vec.z = i_vec.z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

endmodule

// ===== src/ggh_post.sv =====
`timescale 1ns / 1ps
// back end: bearing rounding, error wrap, gain and clamp, speed and mode selection
// depends on ggh_pkg; the last stage is the output register

module ggh_post (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ggh_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ggh_pkg::Z_W-1:0]      i_z,
    input  ggh_pkg::t_side                      i_side,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic                                o_arrived,
    output logic [ggh_pkg::SPEED_W-1:0]         o_speed,
    output logic signed [ggh_pkg::TURN_W-1:0]   o_turn
);

    // stage a: squared distance, rounded bearing, raw error
    logic                                   r_a_valid;
    logic                                   r_a_point;
    logic                                   r_a_minmode;
    logic                                   r_a_near;
    logic [ggh_pkg::SQC_W-1:0]              r_a_sqc;
    logic signed [ggh_pkg::ERR_W-1:0]       r_a_diff;
    // stage b: wrapped error, speed
    logic                                   r_b_valid;
    logic                                   r_b_point;
    logic                                   r_b_minmode;
    logic                                   r_b_near;
    logic [ggh_pkg::SPEED_W-1:0]            r_b_speed;
    logic signed [ggh_pkg::ERR_W-1:0]       r_b_err;
    // stage c: magnitude, compares, gain product
    logic                                   r_c_valid;
    logic                                   r_c_point;
    logic                                   r_c_minmode;
    logic                                   r_c_near;
    logic [ggh_pkg::SPEED_W-1:0]            r_c_speed;
    logic signed [ggh_pkg::ERR_W-1:0]       r_c_err;
    logic                                   r_c_neg;
    logic                                   r_c_below_tol;
    logic                                   r_c_in_win;
    logic [ggh_pkg::PROD_W-1:0]             r_c_prod;
    // stage d: output register
    logic                                   r_d_valid;
    logic                                   r_d_arrived;
    logic [ggh_pkg::SPEED_W-1:0]            r_d_speed;
    logic signed [ggh_pkg::TURN_W-1:0]      r_d_turn;

    logic w_rdy_b;
    logic w_rdy_c;
    logic w_rdy_d;

    logic [ggh_pkg::SUM_W-1:0]              w_sq;
    logic [ggh_pkg::SQC_W-1:0]              w_sqc;
    logic signed [ggh_pkg::Z_W-1:0]         w_zr;
    logic signed [ggh_pkg::TURN_W-1:0]      w_bear;
    logic signed [ggh_pkg::ERR_W-1:0]       n_a_diff;
    logic signed [ggh_pkg::ERR_W-1:0]       n_b_err;
    logic [ggh_pkg::SPD_PROD_W-1:0]         w_spd_prod;
    logic [ggh_pkg::ERR_W-1:0]              w_mag;
    logic [ggh_pkg::WIDE_W-1:0]             w_prod_w;
    logic [ggh_pkg::WIDE_W-1:0]             w_lim_w;
    logic [ggh_pkg::WIDE_W-1:0]             w_min_w;
    logic                                   w_over;
    logic                                   w_nz;
    logic                                   w_low;
    logic [ggh_pkg::LIM_W-1:0]              w_tmag;
    logic [ggh_pkg::LIM_W-1:0]              w_omag;
    logic signed [ggh_pkg::TURN_W-1:0]      w_gturn;
    logic                                   n_d_arrived;
    logic [ggh_pkg::SPEED_W-1:0]            n_d_speed;
    logic signed [ggh_pkg::TURN_W-1:0]      n_d_turn;

    assign w_rdy_d = !r_d_valid || i_ready;
    assign w_rdy_c = !r_c_valid || w_rdy_d;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign o_ready = !r_a_valid || w_rdy_b;

    assign o_valid   = r_d_valid;
    assign o_arrived = r_d_arrived;
    assign o_speed   = r_d_speed;
    assign o_turn    = r_d_turn;

    // stage a
    always_comb begin
        w_sq = ggh_pkg::SUM_W'(i_side.dx2) + ggh_pkg::SUM_W'(i_side.dy2);
        if (w_sq > ggh_pkg::SQ_MAX) begin
            w_sqc = ggh_pkg::SQC_W'(ggh_pkg::SQ_MAX);
        end else if (w_sq < ggh_pkg::SQ_MIN) begin
            w_sqc = ggh_pkg::SQC_W'(ggh_pkg::SQ_MIN);
        end else begin
            w_sqc = w_sq[ggh_pkg::SQC_W-1:0];
        end
        w_zr   = i_z + ggh_pkg::ROUND_HALF;
        // goal on the robot has bearing zero
        w_bear = i_side.zero ? '0 : ggh_pkg::TURN_W'(w_zr >>> ggh_pkg::RND_SHIFT);
        if (i_side.op[1]) begin
            n_a_diff = ggh_pkg::ERR_W'(w_bear) - ggh_pkg::ERR_W'(i_side.ch);
        end else begin
            n_a_diff = ggh_pkg::ERR_W'(i_side.th) - ggh_pkg::ERR_W'(i_side.ch);
        end
    end

    // stage b
    always_comb begin
        if (r_a_diff > ggh_pkg::PI_ERR) begin
            n_b_err = r_a_diff - ggh_pkg::TWO_PI_ERR;
        end else if (r_a_diff < -ggh_pkg::PI_ERR) begin
            n_b_err = r_a_diff + ggh_pkg::TWO_PI_ERR;
        end else begin
            n_b_err = r_a_diff;
        end
        w_spd_prod = ggh_pkg::SPD_PROD_W'(ggh_pkg::SQC_W'(r_a_sqc) + ggh_pkg::SPD_ROUND)
                   * ggh_pkg::SPD_PROD_W'(ggh_pkg::SPD_RECIP);
    end

    // stage c
    always_comb begin
        w_mag = r_b_err[ggh_pkg::ERR_W-1] ? ggh_pkg::ERR_W'(-r_b_err)
                                          : ggh_pkg::ERR_W'(r_b_err);
    end

    // stage d: |clamp(err * gain)| = min(|err| * gain, limit), sign from err
    always_comb begin
        w_prod_w = ggh_pkg::WIDE_W'(r_c_prod);
        w_lim_w  = ggh_pkg::WIDE_W'(i_cfg.lim);
        w_min_w  = ggh_pkg::WIDE_W'(i_cfg.min_rate);
        w_over   = w_prod_w > w_lim_w;
        w_tmag   = w_over ? i_cfg.lim : ggh_pkg::LIM_W'(r_c_prod);
        w_nz     = w_over ? (i_cfg.lim != '0) : (r_c_prod != '0);
        w_low    = r_c_minmode && w_nz &&
                   (w_over ? (w_lim_w < w_min_w) : (w_prod_w < w_min_w));
        w_omag   = w_low ? i_cfg.min_rate : w_tmag;
        w_gturn  = r_c_neg ? -ggh_pkg::TURN_W'(w_omag) : ggh_pkg::TURN_W'(w_omag);

        n_d_arrived = 1'b0;
        n_d_speed   = '0;
        n_d_turn    = '0;
        if (!r_c_point) begin
            n_d_arrived = r_c_below_tol;
            n_d_turn    = r_c_below_tol ? '0 : w_gturn;
        end else if (r_c_near) begin
            n_d_arrived = 1'b1;
        end else if (!r_c_in_win) begin
            // turn in place; inside tolerance it just holds still
            n_d_turn = r_c_below_tol ? '0 : w_gturn;
        end else begin
            n_d_speed = r_c_speed;
            n_d_turn  = ggh_pkg::TURN_W'(r_c_err);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_point   <= i_side.op[1];
            r_a_minmode <= (i_side.op == ggh_pkg::OP_ANGLE_MIN);
            r_a_near    <= w_sq < ggh_pkg::SUM_W'(i_cfg.rad_sq);
            r_a_sqc     <= w_sqc;
            r_a_diff    <= n_a_diff;
        end
        if (w_rdy_b && r_a_valid) begin
            r_b_point   <= r_a_point;
            r_b_minmode <= r_a_minmode;
            r_b_near    <= r_a_near;
            r_b_speed   <= w_spd_prod[ggh_pkg::SPD_SHIFT +: ggh_pkg::SPEED_W];
            r_b_err     <= n_b_err;
        end
        if (w_rdy_c && r_b_valid) begin
            r_c_point     <= r_b_point;
            r_c_minmode   <= r_b_minmode;
            r_c_near      <= r_b_near;
            r_c_speed     <= r_b_speed;
            r_c_err       <= r_b_err;
            r_c_neg       <= r_b_err[ggh_pkg::ERR_W-1];
            r_c_below_tol <= ggh_pkg::WIDE_W'(w_mag) < ggh_pkg::WIDE_W'(i_cfg.tol);
            r_c_in_win    <= ggh_pkg::WIDE_W'(w_mag) <= ggh_pkg::WIDE_W'(i_cfg.win);
            r_c_prod      <= ggh_pkg::PROD_W'(w_mag) * ggh_pkg::PROD_W'(i_cfg.gain);
        end
        if (w_rdy_d && r_c_valid) begin
            r_d_arrived <= n_d_arrived;
            r_d_speed   <= n_d_speed;
            r_d_turn    <= n_d_turn;
        end
    end

endmodule
